FILE: rtl/pcmrs_pkg.sv
// Shared widths, constants and register codes of the PCM linear resampler.
package pcmrs_pkg;

	// Width of the sample counters of the sound.
	localparam int COUNT_BITS = 24;

	// Fixed field widths.
	localparam int SAMPLE_W  = 16;
	localparam int RATE_W    = 18;
	localparam int SCOUNT_W  = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// A count never exceeds what the sample count register can hold.
	localparam int CNT_W = (COUNT_BITS < SCOUNT_W) ? COUNT_BITS : SCOUNT_W;

	// The ratio of rates is at most 24, so the output counter needs five more bits.
	localparam int OUT_W  = CNT_W + 5;
	localparam int PROD_W = OUT_W + RATE_W;
	localparam int DIV_W  = PROD_W;

	// Interpolation numerator: magnitude at most 2**15 times the target rate.
	localparam int MAG_W    = SAMPLE_W - 1 + RATE_W;
	localparam int MAC_HI_W = SAMPLE_W + 2;

	// Step counters of the serial units.
	localparam int MUL_CNT_W = $clog2(RATE_W);
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Result limit for one input sample.
	localparam int MAX_RESULTS = 48;
	localparam int RESULT_W    = $clog2(MAX_RESULTS + 1);

	localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;

	localparam logic [RATE_W-1:0] RATE_LOW     = RATE_W'(8000);
	localparam logic [RATE_W-1:0] RATE_HIGH    = RATE_W'(192000);
	localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(44100);
	localparam logic [7:0]        U8_BIAS      = 8'h80;
	localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_RATE,
		REG_TARGET_RATE,
		REG_EIGHT_BIT,
		REG_SAMPLE_COUNT
	} cfg_reg_t;

endpackage

FILE: rtl/pcmrs_serial_mul.sv
// Unsigned shift-and-add multiplier that retires one multiplier bit per cycle.
module pcmrs_serial_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pcmrs_pkg::OUT_W-1:0]    mcand,
	input  logic [pcmrs_pkg::RATE_W-1:0]   mplier,
	output logic                           done,
	output logic [pcmrs_pkg::PROD_W-1:0]   product
);
	import pcmrs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [OUT_W-1:0]     mcand_q;
	logic [OUT_W:0]       hi_q;
	logic [RATE_W-1:0]    lo_q;
	logic [OUT_W:0]       sum;

	// Add the multiplicand when the low multiplier bit is set.
	assign sum = lo_q[0] ? (hi_q + {1'b0, mcand_q}) : hi_q;

	// Load on start, then shift the partial product right once per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			mcand_q <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= MUL_CNT_W'(RATE_W - 1);
				mcand_q <= mcand;
				hi_q    <= '0;
				lo_q    <= mplier;
			end else if (busy_q) begin
				hi_q <= {1'b0, sum[OUT_W:1]};
				lo_q <= {sum[0], lo_q[RATE_W-1:1]};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = {hi_q[OUT_W-1:0], lo_q};

endmodule

FILE: rtl/pcmrs_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pcmrs_serial_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcmrs_pkg::DIV_W-1:0]   dividend,
	input  logic [pcmrs_pkg::RATE_W-1:0]  divisor,
	output logic                          done,
	output logic [pcmrs_pkg::DIV_W-1:0]   quotient,
	output logic [pcmrs_pkg::RATE_W-1:0]  remainder
);
	import pcmrs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    dsr_q;
	logic [RATE_W:0]      shifted;
	logic [RATE_W:0]      diff;
	logic                 fits;

	// Bring in the next dividend bit and try the subtraction.
	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	// Quotient bits fill the dividend register from the bottom as it empties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
				dvd_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/pcmrs_interp_mac.sv
// Serial signed multiply-accumulate for a*wa + b*wb, one weight bit per cycle.
module pcmrs_interp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pcmrs_pkg::SAMPLE_W-1:0] a,
	input  logic signed [pcmrs_pkg::SAMPLE_W-1:0] b,
	input  logic        [pcmrs_pkg::RATE_W-1:0]   wa,
	input  logic        [pcmrs_pkg::RATE_W-1:0]   wb,
	output logic                                 done,
	output logic                                 neg,
	output logic        [pcmrs_pkg::MAG_W-1:0]    mag
);
	import pcmrs_pkg::*;

	logic                         busy_q;
	logic                         done_q;
	logic [MUL_CNT_W-1:0]         cnt_q;
	logic signed [SAMPLE_W-1:0]   a_q;
	logic signed [SAMPLE_W-1:0]   b_q;
	logic [RATE_W-1:0]            wa_q;
	logic [RATE_W-1:0]            wb_q;
	logic [MAC_HI_W-1:0]          hi_q;
	logic [RATE_W-1:0]            lo_q;
	logic [MAC_HI_W:0]            ext_hi;
	logic [MAC_HI_W:0]            ext_a;
	logic [MAC_HI_W:0]            ext_b;
	logic [MAC_HI_W:0]            sum;
	logic [MAC_HI_W+RATE_W-1:0]   num;
	logic [MAC_HI_W+RATE_W-1:0]   num_abs;

	// Sign-extend the partial sum and both samples to the adder width.
	assign ext_hi = {hi_q[MAC_HI_W-1], hi_q};
	assign ext_a  = {{(MAC_HI_W + 1 - SAMPLE_W){a_q[SAMPLE_W-1]}}, a_q};
	assign ext_b  = {{(MAC_HI_W + 1 - SAMPLE_W){b_q[SAMPLE_W-1]}}, b_q};
	assign sum    = ext_hi + (wa_q[0] ? ext_a : '0) + (wb_q[0] ? ext_b : '0);

	// Each cycle adds the selected samples and shifts the sum right arithmetically.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			wa_q   <= '0;
			wb_q   <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(RATE_W - 1);
				a_q    <= a;
				b_q    <= b;
				wa_q   <= wa;
				wb_q   <= wb;
				hi_q   <= '0;
				lo_q   <= '0;
			end else if (busy_q) begin
				hi_q <= sum[MAC_HI_W:1];
				lo_q <= {sum[0], lo_q[RATE_W-1:1]};
				wa_q <= {1'b0, wa_q[RATE_W-1:1]};
				wb_q <= {1'b0, wb_q[RATE_W-1:1]};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Sign and magnitude of the finished numerator.
	assign num     = {hi_q, lo_q};
	assign num_abs = hi_q[MAC_HI_W-1] ? (~num + 1'b1) : num;
	assign neg     = hi_q[MAC_HI_W-1];
	assign mag     = num_abs[MAG_W-1:0];
	assign done    = done_q;

endmodule

FILE: rtl/pcm_linear_resampler.sv
// Top level of the PCM linear resampler: registers, sequencer and output stage.
//
//   Channel   Handshake                Payload
//   input     raw_valid / raw_stall    raw_sample
//   output    res_valid / res_stall    out_sample, run_end
//   config    cfg_write                cfg_index, cfg_data
//
// Each result takes a serial multiply for the output position, a serial divide for its whole
// part and phase, a serial multiply-accumulate for the numerator, a serial divide by the target
// rate and a push step to hand the result on.
// Each sample also takes acceptance, the total multiply, the closing position multiply and the
// flush, and also the whole-part divide when the closing check needs it.
// One sample is worked at a time; raw_stall is high from acceptance to completion.
// A stall on the output holds the sequencer only when a finished result has nowhere to go.
// Reset is asynchronous and clears all counters; no clearing pass is needed.
module pcm_linear_resampler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic        [pcmrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pcmrs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                                  raw_valid,
	output logic                                  raw_stall,
	input  logic        [pcmrs_pkg::SAMPLE_W-1:0]  raw_sample,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [pcmrs_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                  run_end
);
	import pcmrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_POS,
		ST_WHOLE,
		ST_MAC,
		ST_QUO,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	// Configuration.
	logic [RATE_W-1:0]          src_q;
	logic [RATE_W-1:0]          dst_q;
	logic                       eight_q;
	logic [CNT_W-1:0]           count_q;

	// Stream state and working registers.
	state_t                     state_q;
	logic [CNT_W-1:0]           k_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] cur_q;
	logic [OUT_W-1:0]           outs_q;
	logic [RESULT_W-1:0]        n_q;
	logic [CNT_W+RATE_W-1:0]    cnt_dst_q;
	logic [PROD_W-1:0]          pos_q;
	logic [RATE_W-1:0]          phase_q;
	logic                       pick_prev_q;
	logic [SAMPLE_W-1:0]        val_q;
	logic [SAMPLE_W-1:0]        pend_q;
	logic                       pend_valid_q;
	logic                       mul_start_q;
	logic                       div_start_q;
	logic                       mac_start_q;

	// Output register.
	logic                       res_valid_q;
	logic [SAMPLE_W-1:0]        out_sample_q;
	logic                       run_end_q;

	// Unit connections.
	logic [OUT_W-1:0]           mul_mcand;
	logic [RATE_W-1:0]          mul_mplier;
	logic                       mul_done;
	logic [PROD_W-1:0]          mul_product;
	logic [DIV_W-1:0]           div_dividend;
	logic                       div_done;
	logic [DIV_W-1:0]           div_quo;
	logic [RATE_W-1:0]          div_rem;
	logic signed [SAMPLE_W-1:0] mac_a;
	logic [RATE_W-1:0]          mac_wa;
	logic                       mac_done;
	logic                       mac_neg;
	logic [MAG_W-1:0]           mac_mag;

	// Sequencer decisions.
	logic                       in_take;
	logic                       out_free;
	logic [PROD_W:0]            pos_next;
	logic                       total_hit;
	logic [CNT_W-1:0]           whole;
	logic                       use_prev;
	logic                       use_cur;
	logic [SCOUNT_W-1:0]        cnt_in;

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] res;
		if (r < RATE_LOW) begin
			res = RATE_LOW;
		end else if (r > RATE_HIGH) begin
			res = RATE_HIGH;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Unsigned 8-bit samples are re-biased by flipping the top bit and scaled by 256.
	function automatic logic [SAMPLE_W-1:0] convert(input logic [SAMPLE_W-1:0] raw,
			input logic eight);
		logic [SAMPLE_W-1:0] res;
		if (eight) begin
			res = {raw[7:0] ^ U8_BIAS, 8'h00};
		end else begin
			res = raw;
		end
		return res;
	endfunction

	// Apply the sign to the quotient magnitude and clip to the sample range.
	function automatic logic [SAMPLE_W-1:0] saturate(input logic [DIV_W-1:0] q,
			input logic neg);
		logic [SAMPLE_W-1:0] res;
		if (!neg) begin
			res = (q > DIV_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : q[SAMPLE_W-1:0];
		end else if (q > DIV_W'(SAMPLE_MAX + 1)) begin
			res = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			res = ~q[SAMPLE_W-1:0] + 1'b1;
		end
		return res;
	endfunction

	// Configuration writes; rates and count are stored already limited.
	assign cnt_in = cfg_data[SCOUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= DEFAULT_RATE;
			dst_q   <= DEFAULT_RATE;
			eight_q <= 1'b0;
			count_q <= CNT_W'(1);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SOURCE_RATE: begin
					src_q <= clamp_rate(cfg_data[RATE_W-1:0]);
				end
				REG_TARGET_RATE: begin
					dst_q <= clamp_rate(cfg_data[RATE_W-1:0]);
				end
				REG_EIGHT_BIT: begin
					eight_q <= cfg_data[0];
				end
				REG_SAMPLE_COUNT: begin
					if (cnt_in == '0) begin
						count_q <= CNT_W'(1);
					end else if (cnt_in > SCOUNT_W'(COUNT_MAX)) begin
						count_q <= COUNT_MAX;
					end else begin
						count_q <= cnt_in[CNT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operand selection for the serial units; the multiplier and the divider are shared.
	assign mul_mcand    = (state_q == ST_TOTAL) ? OUT_W'(count_q) : outs_q;
	assign mul_mplier   = (state_q == ST_TOTAL) ? dst_q : src_q;
	assign div_dividend = (state_q == ST_WHOLE) ? pos_q : DIV_W'(mac_mag);
	assign mac_a        = pick_prev_q ? prev_q : cur_q;
	assign mac_wa       = dst_q - phase_q;

	pcmrs_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.done    (mul_done),
		.product (mul_product)
	);

	pcmrs_serial_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dividend),
		.divisor   (dst_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	pcmrs_interp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start_q),
		.a      (mac_a),
		.b      (cur_q),
		.wa     (mac_wa),
		.wb     (phase_q),
		.done   (mac_done),
		.neg    (mac_neg),
		.mag    (mac_mag)
	);

	// Handshake and decision terms.
	assign in_take   = raw_valid && !raw_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign pos_next  = {1'b0, mul_product} + (PROD_W + 1)'(src_q);
	assign total_hit = pos_next > (PROD_W + 1)'(cnt_dst_q);
	assign whole     = div_quo[CNT_W-1:0];
	assign use_prev  = (k_q != '0) && (whole < k_q);
	assign use_cur   = (whole == k_q) && (({1'b0, k_q} + 1'b1) == {1'b0, count_q});

	// Sequencer: one sample at a time, results handed out through a pending register
	// so that the last one of a sample can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			outs_q       <= '0;
			n_q          <= '0;
			cnt_dst_q    <= '0;
			pos_q        <= '0;
			phase_q      <= '0;
			pick_prev_q  <= 1'b0;
			val_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			mac_start_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			out_sample_q <= '0;
			run_end_q    <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			mac_start_q <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take && (k_q < count_q)) begin
						cur_q       <= convert(raw_sample, eight_q);
						n_q         <= '0;
						mul_start_q <= 1'b1;
						state_q     <= ST_TOTAL;
					end
				end
				ST_TOTAL: begin
					if (mul_done) begin
						cnt_dst_q   <= mul_product[CNT_W+RATE_W-1:0];
						mul_start_q <= 1'b1;
						state_q     <= ST_POS;
					end
				end
				ST_POS: begin
					if (mul_done) begin
						if ((n_q == RESULT_W'(MAX_RESULTS)) || total_hit) begin
							state_q <= ST_FLUSH;
						end else begin
							pos_q       <= mul_product;
							div_start_q <= 1'b1;
							state_q     <= ST_WHOLE;
						end
					end
				end
				ST_WHOLE: begin
					if (div_done) begin
						phase_q <= div_rem;
						if (use_prev || use_cur) begin
							pick_prev_q <= use_prev;
							mac_start_q <= 1'b1;
							state_q     <= ST_MAC;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_MAC: begin
					if (mac_done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_QUO;
					end
				end
				ST_QUO: begin
					if (div_done) begin
						val_q   <= saturate(div_quo, mac_neg);
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							res_valid_q  <= 1'b1;
							out_sample_q <= pend_q;
							run_end_q    <= 1'b0;
						end
						pend_q       <= val_q;
						pend_valid_q <= 1'b1;
						outs_q       <= outs_q + 1'b1;
						n_q          <= n_q + 1'b1;
						mul_start_q  <= 1'b1;
						state_q      <= ST_POS;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							res_valid_q  <= 1'b1;
							out_sample_q <= pend_q;
							run_end_q    <= 1'b1;
						end
						pend_valid_q <= 1'b0;
						prev_q       <= cur_q;
						k_q          <= k_q + 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign raw_stall  = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;
	assign out_sample = out_sample_q;
	assign run_end    = run_end_q;

`ifndef ASSERT_OFF
	// No result may be left behind when a sample completes.
	a_pend_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left over at end of sample");

	// A sample never gives more results than the limit.
	a_results_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RESULT_W'(MAX_RESULTS))
		else $error("too many results for one sample");

	// The output counter advances only when a result is handed on.
	a_outs_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(outs_q) |-> ($past(state_q) == ST_PUSH))
		else $error("output counter moved outside a result transaction");
`endif

endmodule
